// ----- hdl/frame_difference_scene_cut_detector_top_assert.svh -----
// Assertion macros used by the detector RTL.
// Both sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef FRAME_DIFFERENCE_SCENE_CUT_DETECTOR_TOP_ASSERT_SVH
`define FRAME_DIFFERENCE_SCENE_CUT_DETECTOR_TOP_ASSERT_SVH

// Same-cycle implication: when ante holds, cons holds.
`define FDSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons holds in the next cycle.
`define FDSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/fdsc_pkg.sv -----
package fdsc_pkg;

  localparam int PIX_W   = 8;
  localparam int SCORE_W = 16;
  localparam int CFG_AW  = 4;
  localparam int CFG_DW  = 32;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_QUIET = 2'd0;
  localparam logic [1:0] REG_JUMP  = 2'd1;
  localparam logic [1:0] REG_HARD  = 2'd2;

  localparam logic [SCORE_W-1:0] QUIET_RST = 16'd1280;
  localparam logic [SCORE_W-1:0] JUMP_RST  = 16'd7680;
  localparam logic [SCORE_W-1:0] HARD_RST  = 16'd12800;

  // Decision constants, scaled so the tests stay integer
  localparam int K_THR_MX = 18;   // 10 * 1.8
  localparam int K_THR_MN = 8;    // 10 * 0.8
  localparam int K_S10    = 10;
  localparam int K_P14    = 14;   // 10 * 1.4
  localparam int K_S100   = 100;
  localparam int K_FAR_MX = 414;  // 23 * 18
  localparam int K_FAR_MN = 184;  // 23 * 8

  typedef struct packed {
    logic [PIX_W-1:0] old_pixel;
    logic [PIX_W-1:0] new_pixel;
    logic             last_pixel;
  } in_item_t;

  typedef struct packed {
    logic               scene_cut;
    logic [SCORE_W-1:0] frame_score;
  } out_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic [SCORE_W-1:0] quiet_floor;
    logic [SCORE_W-1:0] jump_floor;
    logic [SCORE_W-1:0] hard_floor;
  } cfg_t;

endpackage

// ----- hdl/frame_difference_scene_cut_detector_top.sv -----
// Frame-difference scene cut detector.
// Input channel (in_valid / in_stall / in_data): one co-located pixel pair
// per transaction, old and new byte plus last_pixel marking the frame's end.
// Pixels are taken at one per cycle; in_stall rises only while two finished
// frames wait in the frame queue for the decision engine.
// Result channel (out_valid / out_stall / out_data): one transaction per
// frame, with the 8.8 mean absolute difference and the scene_cut flag.
// out_valid is set after the last pixel's transaction writes the queue and
// the back end pops and loads the frame, runs the bit-per-cycle score divider
// over the 16 score bits, forms the ratio products and decides; it takes a
// new frame only after that decision. A stalled result is held in the output
// register; the decision engine then waits, the queue fills, and only then
// is the pixel input stalled. Reset clears the sums, the score window, the
// fill count and the queue and loads the floors with 5.0, 30.0 and 50.0.
// The user writes floors over the APB-style port (byte addresses 0, 4, 8)
// only while no frame is in flight; the block does not enforce it.
module frame_difference_scene_cut_detector_top import fdsc_pkg::*; #(
  parameter int WINDOW     = 5,
  parameter int MAX_PIXELS = 4194304
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int CW = $clog2(MAX_PIXELS + 1);
  localparam int SW = CW + PIX_W;

  cfg_t             cfg_r;
  logic [1:0]       reg_idx;
  logic             cfg_wr;
  fifo_stat_t       q_stat;
  logic             push, pop;
  logic [SW-1:0]    push_sum;
  logic [CW-1:0]    push_count;
  logic [SW+CW-1:0] q_rdata;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.quiet_floor <= QUIET_RST;
      cfg_r.jump_floor  <= JUMP_RST;
      cfg_r.hard_floor  <= HARD_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_QUIET: cfg_r.quiet_floor <= cfg_pwdata[SCORE_W-1:0];
        REG_JUMP:  cfg_r.jump_floor  <= cfg_pwdata[SCORE_W-1:0];
        REG_HARD:  cfg_r.hard_floor  <= cfg_pwdata[SCORE_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_QUIET: cfg_prdata = CFG_DW'(cfg_r.quiet_floor);
      REG_JUMP:  cfg_prdata = CFG_DW'(cfg_r.jump_floor);
      REG_HARD:  cfg_prdata = CFG_DW'(cfg_r.hard_floor);
      default:   cfg_prdata = '0;
    endcase
  end

  // Pixel accumulator
  fdsc_front #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .q_stat     (q_stat),
    .push       (push),
    .push_sum   (push_sum),
    .push_count (push_count)
  );

  // Frame totals queue
  fdsc_fifo #(
    .DW (SW + CW)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata ({push_sum, push_count}),
    .pop   (pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // Score and decision engine
  fdsc_back #(
    .WINDOW     (WINDOW),
    .MAX_PIXELS (MAX_PIXELS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_rdata   (q_rdata),
    .pop       (pop),
    .cfg       (cfg_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- hdl/fdsc_front.sv -----
module fdsc_front import fdsc_pkg::*; #(
  parameter int MAX_PIXELS = 4194304,
  localparam int CW = $clog2(MAX_PIXELS + 1),
  localparam int SW = CW + PIX_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  in_item_t      in_data,
  input  fifo_stat_t    q_stat,
  output logic          push,
  output logic [SW-1:0] push_sum,
  output logic [CW-1:0] push_count
);

  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PIXELS);

  logic [SW-1:0]    sum_r, sum_nxt, sum_cur;
  logic [CW-1:0]    count_r, count_nxt, count_cur;
  logic [PIX_W-1:0] diff;
  logic             take;

  // Hold the input while the frame queue is full
  assign in_stall = q_stat.full;
  assign take     = in_valid & ~q_stat.full;

  // Accumulate |old - new|, saturating the pixel count
  always_comb begin
    diff = (in_data.old_pixel > in_data.new_pixel) ?
           (in_data.old_pixel - in_data.new_pixel) :
           (in_data.new_pixel - in_data.old_pixel);
    if (count_r != MAX_CNT) begin
      sum_cur   = sum_r + SW'(diff);
      count_cur = count_r + 1'b1;
    end else begin
      sum_cur   = sum_r;
      count_cur = count_r;
    end
    sum_nxt   = sum_r;
    count_nxt = count_r;
    if (take) begin
      if (in_data.last_pixel) begin
        sum_nxt   = '0;
        count_nxt = '0;
      end else begin
        sum_nxt   = sum_cur;
        count_nxt = count_cur;
      end
    end
  end

  // Queue the frame totals on the last pixel
  assign push       = take & in_data.last_pixel;
  assign push_sum   = sum_cur;
  assign push_count = count_cur;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      count_r <= '0;
    end else begin
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ----- hdl/fdsc_fifo.sv -----
module fdsc_fifo import fdsc_pkg::*; #(
  parameter int DW = 56
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  input  logic          pop,
  output logic [DW-1:0] rdata,
  output fifo_stat_t    stat
);

  logic [DW-1:0] mem_r [2];
  logic          wptr_r, rptr_r;
  logic [1:0]    cnt_r;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign rdata      = mem_r[rptr_r];

  // Store frame totals
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- hdl/fdsc_back.sv -----
`include "frame_difference_scene_cut_detector_top_assert.svh"

module fdsc_back import fdsc_pkg::*; #(
  parameter int WINDOW     = 5,
  parameter int MAX_PIXELS = 4194304,
  localparam int CW = $clog2(MAX_PIXELS + 1),
  localparam int SW = CW + PIX_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  fifo_stat_t       q_stat,
  input  logic [SW+CW-1:0] q_rdata,
  output logic             pop,
  input  cfg_t             cfg,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data
);

  localparam int IDX_W = $clog2(WINDOW);
  localparam int FW    = $clog2(WINDOW + 1);
  localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(2);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(WINDOW - 1);
  localparam logic [FW-1:0]    FILL_MAX  = FW'(WINDOW);
  localparam logic [FW-1:0]    FILL_PRE  = FW'(WINDOW - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DEC  = 3'd3;

  logic [2:0]         state_r;
  logic [SCORE_W-1:0] win_r [WINDOW];
  logic [FW-1:0]      fill_r;

  // Divider
  logic [CW:0]        rem_r, rem_sh, rem_dif;
  logic [CW-1:0]      cnt_r;
  logic [SCORE_W-1:0] lo_r, q_r;
  logic [3:0]         step_r;
  logic               ge;

  // Window scan
  logic [SCORE_W-1:0] mx_r, mn_r, scan_val;
  logic [IDX_W-1:0]   idx_r;
  logic               scan_on_r;

  // Products
  logic signed [22:0] t10_r;
  logic signed [26:0] t23_r;
  logic [22:0]        s100_r;
  logic [19:0]        s10_r, p14_r;

  // Decision
  logic signed [22:0] s10_sx;
  logic signed [26:0] s100_sx;
  logic [SCORE_W-1:0] prev;
  logic               fill_ok, quiet, below, jump_hit, far_hit, hard_hit, cut;
  logic               slot_free, emit;
  logic [SW-1:0]      q_sum;
  logic [CW-1:0]      q_count;

  logic               out_valid_r;
  out_item_t          out_data_r;

  assign q_sum   = q_rdata[SW+CW-1:CW];
  assign q_count = q_rdata[CW-1:0];
  assign pop     = (state_r == ST_IDLE) & ~q_stat.empty;

  // One restoring division step per cycle
  always_comb begin
    rem_sh  = {rem_r[CW-1:0], lo_r[SCORE_W-1]};
    ge      = (rem_sh >= {1'b0, cnt_r});
    rem_dif = rem_sh - {1'b0, cnt_r};
  end

  assign scan_val = win_r[idx_r];
  assign prev     = win_r[WINDOW-1];

  // Evaluate the cut ladder on registered products
  always_comb begin
    s10_sx   = signed'({3'b000, s10_r});
    s100_sx  = signed'({4'b0000, s100_r});
    fill_ok  = (fill_r >= FILL_PRE);
    quiet    = (q_r < cfg.quiet_floor);
    below    = (t10_r < 23'sd0) || ((t10_r > 23'sd0) && (s10_sx < t10_r));
    jump_hit = (q_r > cfg.jump_floor) &&
               ((prev == '0) ? (q_r != '0) : (s10_r > p14_r));
    far_hit  = (t10_r == 23'sd0) ? (q_r != '0) : (s100_sx > t23_r);
    hard_hit = (q_r > cfg.hard_floor);
    cut      = fill_ok & ~quiet & ~below & (jump_hit | far_hit | hard_hit);
  end

  assign slot_free = ~out_valid_r | ~out_stall;
  assign emit      = (state_r == ST_DEC) & slot_free;

  // Sequence one frame: divide and scan, multiply, decide
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      scan_on_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (pop) begin
            state_r   <= ST_DIV;
            scan_on_r <= 1'b1;
          end
        end
        ST_DIV: begin
          if (scan_on_r && (idx_r == IDX_LAST)) begin
            scan_on_r <= 1'b0;
          end
          if (step_r == 4'd15) begin
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          state_r <= ST_DEC;
        end
        ST_DEC: begin
          if (slot_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers for divider, scan and products
  always_ff @(posedge clk) begin
    if (pop) begin
      rem_r  <= {1'b0, q_sum[SW-1:PIX_W]};
      lo_r   <= {q_sum[PIX_W-1:0], {(SCORE_W-PIX_W){1'b0}}};
      cnt_r  <= q_count;
      q_r    <= '0;
      step_r <= '0;
      mx_r   <= win_r[1];
      mn_r   <= win_r[1];
      idx_r  <= IDX_FIRST;
    end
    if (state_r == ST_DIV) begin
      rem_r  <= ge ? rem_dif : rem_sh;
      lo_r   <= {lo_r[SCORE_W-2:0], 1'b0};
      q_r    <= {q_r[SCORE_W-2:0], ge};
      step_r <= step_r + 4'd1;
      if (scan_on_r) begin
        if (scan_val > mx_r) begin
          mx_r <= scan_val;
        end
        if (scan_val < mn_r) begin
          mn_r <= scan_val;
        end
        if (idx_r != IDX_LAST) begin
          idx_r <= idx_r + 1'b1;
        end
      end
    end
    if (state_r == ST_MUL) begin
      t10_r  <= 23'(signed'({7'd0, mx_r}) * K_THR_MX) -
                23'(signed'({7'd0, mn_r}) * K_THR_MN);
      t23_r  <= 27'(signed'({11'd0, mx_r}) * K_FAR_MX) -
                27'(signed'({11'd0, mn_r}) * K_FAR_MN);
      s100_r <= 23'(q_r * K_S100);
      s10_r  <= 20'(q_r * K_S10);
      p14_r  <= 20'(prev * K_P14);
    end
  end

  // Shift the score into the window, or clear it on a cut
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) begin
        win_r[i] <= '0;
      end
      fill_r <= '0;
    end else if (emit) begin
      if (cut) begin
        for (int i = 0; i < WINDOW; i++) begin
          win_r[i] <= '0;
        end
        fill_r <= '0;
      end else begin
        for (int i = 0; i < WINDOW - 1; i++) begin
          win_r[i] <= win_r[i+1];
        end
        win_r[WINDOW-1] <= q_r;
        if (fill_r != FILL_MAX) begin
          fill_r <= fill_r + 1'b1;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.scene_cut   <= cut;
      out_data_r.frame_score <= q_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `FDSC_ASSERT_IMP(a_rem_below_div, state_r == ST_DIV, rem_r < {1'b0, cnt_r}, "divider remainder out of range")
  `FDSC_ASSERT_IMP(a_score_range, state_r == ST_MUL, q_r <= 16'd65280, "frame score above 8.8 maximum")
  `FDSC_ASSERT_IMP(a_emit_from_dec, $rose(out_valid_r), $past(state_r) == ST_DEC, "result raised outside decision")
  `FDSC_ASSERT_NXT(a_cut_clears, emit && cut, (fill_r == '0) && (win_r[WINDOW-1] == '0), "window not cleared after cut")

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import fdsc_pkg::*;

  localparam int WINDOW       = 5;
  localparam int MAX_PIX      = 4194304;
  localparam int SCORE_CEIL   = 65280;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int IN_W         = $bits(in_item_t);
  localparam logic [1:0] REG_SPARE = 2'd3;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_stall;
  in_item_t          in_data     = '0;
  logic              out_valid;
  logic              out_stall   = 1'b0;
  out_item_t         out_data;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [CFG_DW-1:0] cfg_pwdata  = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  // Predicted detector state
  logic [SCORE_W-1:0] win_scores [WINDOW];
  int                 win_fill;
  longint             acc_diff;
  longint             acc_pixels;
  logic [SCORE_W-1:0] floor_quiet;
  logic [SCORE_W-1:0] floor_jump;
  logic [SCORE_W-1:0] floor_hard;

  out_item_t frame_verdicts[$];
  int        mismatches     = 0;
  int        pairs_sent     = 0;
  int        cycle_count    = 0;
  int        stall_left     = 0;
  bit        idling_enabled = 1'b1;
  bit        tx_idle_on     = 1'b1;
  bit        rx_idle_on     = 1'b1;

  frame_difference_scene_cut_detector_top #(
    .WINDOW     (WINDOW),
    .MAX_PIXELS (MAX_PIX)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL frame_difference_scene_cut_detector_top");
      $finish;
    end
  end

  task automatic log_mismatch(string what, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endtask

  // Cut ladder over the earlier WINDOW-1 scores; s is already in the window
  function automatic bit judge_scene_cut(logic [SCORE_W-1:0] s);
    longint mx;
    longint mn;
    longint p;
    longint t10;
    longint sv;
    int     i;
    mx = win_scores[0];
    mn = win_scores[0];
    for (i = 1; i < WINDOW - 1; i++) begin
      if (win_scores[i] > mx) mx = win_scores[i];
      if (win_scores[i] < mn) mn = win_scores[i];
    end
    p   = win_scores[WINDOW-2];
    t10 = K_THR_MX * mx - K_THR_MN * mn;
    sv  = s;
    if (win_fill < WINDOW) return 1'b0;
    if (sv < longint'(floor_quiet)) return 1'b0;
    if (t10 < 0) return 1'b0;
    if (t10 > 0 && K_S10 * sv < t10) return 1'b0;
    if (sv > longint'(floor_jump)) begin
      if (p == 0 ? sv > 0 : K_S10 * sv > K_P14 * p) return 1'b1;
    end
    if (t10 == 0) begin
      if (sv > 0) return 1'b1;
    end else if (K_S100 * sv > K_FAR_MX * mx - K_FAR_MN * mn) begin
      return 1'b1;
    end
    if (sv > longint'(floor_hard)) return 1'b1;
    return 1'b0;
  endfunction

  // Accumulate one accepted pixel pair; close the frame on its last pair
  task automatic track_pixel_pair(in_item_t px);
    int        d;
    int        i;
    longint    score;
    bit        cut;
    out_item_t verdict;
    d = (px.old_pixel > px.new_pixel) ? int'(px.old_pixel) - int'(px.new_pixel)
                                      : int'(px.new_pixel) - int'(px.old_pixel);
    if (acc_pixels < MAX_PIX) begin
      acc_diff   += d;
      acc_pixels += 1;
    end
    if (px.last_pixel) begin
      score = (acc_pixels == 0) ? 0 : (acc_diff * 256) / acc_pixels;
      if (score > SCORE_CEIL) score = SCORE_CEIL;
      acc_diff   = 0;
      acc_pixels = 0;
      for (i = 0; i < WINDOW - 1; i++) win_scores[i] = win_scores[i+1];
      win_scores[WINDOW-1] = score[SCORE_W-1:0];
      if (win_fill < WINDOW) win_fill++;
      cut = judge_scene_cut(score[SCORE_W-1:0]);
      if (cut) begin
        for (i = 0; i < WINDOW; i++) win_scores[i] = '0;
        win_fill = 0;
      end
      verdict.scene_cut   = cut;
      verdict.frame_score = score[SCORE_W-1:0];
      frame_verdicts = {frame_verdicts, verdict};
    end
  endtask

  // Send one pair, with an occasional idle burst in front of it
  task automatic drive_pixel_pair(in_item_t px);
    int gap;
    if (tx_idle_on && $urandom_range(0, 11) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      in_data  <= IN_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pairs_sent++;
    track_pixel_pair(px);
  endtask

  function automatic in_item_t make_pair(logic [7:0] a, logic [7:0] b, logic last);
    in_item_t px;
    px.old_pixel  = a;
    px.new_pixel  = b;
    px.last_pixel = last;
    return px;
  endfunction

  // Frame of len pairs whose absolute differences sit near level
  task automatic send_frame(int len, int level, int spread);
    in_item_t px;
    int       d;
    int       k;
    for (k = 0; k < len; k++) begin
      d = level - spread + int'($urandom_range(0, 2 * spread));
      if (d < 0) d = 0;
      if (d > 255) d = 255;
      px.old_pixel = 8'($urandom_range(0, 255 - d));
      px.new_pixel = 8'(int'(px.old_pixel) + d);
      if ($urandom_range(0, 1))
        {px.old_pixel, px.new_pixel} = {px.new_pixel, px.old_pixel};
      px.last_pixel = (k == len - 1);
      drive_pixel_pair(px);
    end
  endtask

  // Mostly short frames; some longer ones
  function automatic int pick_len();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 12);
  endfunction

  // Hold the input until every pending verdict has come out
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frame_verdicts.size() != 0) @(posedge clk);
  endtask

  // Drain, then let the decision pipeline settle before touching registers
  task automatic wait_idle();
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_floor(logic [1:0] idx, logic [15:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {16'($urandom), val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_QUIET: floor_quiet = val;
      REG_JUMP:  floor_jump  = val;
      REG_HARD:  floor_hard  = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic check_floor(logic [1:0] idx);
    logic [15:0] want;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_QUIET: want = floor_quiet;
      REG_JUMP:  want = floor_jump;
      default:   want = floor_hard;
    endcase
    if (cfg_prdata[15:0] !== want)
      log_mismatch("register readback", want, cfg_prdata[15:0]);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Program all floors, poke the unmapped slot, read the three floors back
  task automatic apply_floors(logic [15:0] q, logic [15:0] j, logic [15:0] h);
    wait_idle();
    write_floor(REG_QUIET, q);
    write_floor(REG_JUMP, j);
    write_floor(REG_HARD, h);
    write_floor(REG_SPARE, 16'($urandom));
    check_floor(REG_QUIET);
    check_floor(REG_JUMP);
    check_floor(REG_HARD);
  endtask

  // Scenes of steady frames, cuts, all-zero runs and noise
  task automatic run_scenes(int budget);
    int target;
    int level;
    int mode;
    target = pairs_sent + budget;
    while (pairs_sent < target) begin
      tx_idle_on = idling_enabled && ($urandom_range(0, 3) != 0);
      rx_idle_on = idling_enabled && ($urandom_range(0, 3) != 0);
      mode = $urandom_range(0, 19);
      if (mode < 3) begin
        send_frame(pick_len(), $urandom_range(0, 255), 255);
      end else if (mode < 6) begin
        repeat ($urandom_range(3, 7)) send_frame(pick_len(), 0, 0);
      end else begin
        level = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 60);
        repeat ($urandom_range(3, 7)) send_frame(pick_len(), level, $urandom_range(0, 4));
        if ($urandom_range(0, 1))
          send_frame(pick_len(), level + $urandom_range(5, 200), 3);
      end
    end
  endtask

  task automatic test_reset_floors();
    check_floor(REG_QUIET);
    check_floor(REG_JUMP);
    check_floor(REG_HARD);
  endtask

  task automatic test_directed_frames();
    int k;
    // Full-scale differences both ways
    drive_pixel_pair(make_pair(8'h00, 8'hFF, 1'b1));
    drive_pixel_pair(make_pair(8'hFF, 8'h00, 1'b1));
    // Identical pixels at both ends of the range
    drive_pixel_pair(make_pair(8'h00, 8'h00, 1'b0));
    drive_pixel_pair(make_pair(8'hFF, 8'hFF, 1'b1));
    drive_pixel_pair(make_pair(8'hAA, 8'h55, 1'b0));
    drive_pixel_pair(make_pair(8'h55, 8'hAA, 1'b1));
    // Window now full, score well under the threshold
    drive_pixel_pair(make_pair(8'h55, 8'hAA, 1'b1));
    // Zero score, under the quiet floor
    drive_pixel_pair(make_pair(8'h00, 8'h00, 1'b1));
    // Longer frame of small differences with a full-scale tail
    for (k = 0; k < 10; k++) begin
      if (k < 8)
        drive_pixel_pair(make_pair(8'h10, 8'h11, 1'b0));
      else
        drive_pixel_pair(make_pair(8'h00, 8'hFF, k == 9));
    end
    // Large jump over a low history
    drive_pixel_pair(make_pair(8'h00, 8'hFF, 1'b1));
  endtask

  task automatic test_floor_sweep();
    apply_floors(16'd0, 16'd0, 16'd0);
    run_scenes(50);
    apply_floors(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_scenes(50);
    apply_floors(16'd0, 16'hFFFF, 16'd0);
    run_scenes(50);
    apply_floors(16'($urandom_range(0, 4000)), 16'($urandom_range(2000, 20000)),
                 16'($urandom_range(5000, 30000)));
    run_scenes(50);
    apply_floors(QUIET_RST, JUMP_RST, HARD_RST);
    run_scenes(50);
  endtask

  task automatic test_random_scenes();
    run_scenes(60);
    hold_until_drained();
    run_scenes(60);
  endtask

  task automatic test_steady_stream();
    idling_enabled = 1'b0;
    tx_idle_on     = 1'b0;
    rx_idle_on     = 1'b0;
    run_scenes(40);
  endtask

  // Receiver stalls in random bursts
  always @(posedge clk) begin
    if (!rx_idle_on) begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if ($urandom_range(0, 15) == 0) begin
      stall_left <= $urandom_range(0, 18);
      out_stall  <= 1'b1;
    end else begin
      out_stall  <= 1'b0;
    end
  end

  // Compare each result transaction with the oldest predicted verdict
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (frame_verdicts.size() == 0) begin
        log_mismatch("unexpected result, score", 0, out_data.frame_score);
      end else begin
        want = frame_verdicts.pop_front();
        if (out_data.scene_cut !== want.scene_cut)
          log_mismatch("scene_cut", want.scene_cut, out_data.scene_cut);
        if (out_data.frame_score !== want.frame_score)
          log_mismatch("frame_score", want.frame_score, out_data.frame_score);
      end
    end
  end

  initial begin
    int i;
    for (i = 0; i < WINDOW; i++) win_scores[i] = '0;
    win_fill    = 0;
    acc_diff    = 0;
    acc_pixels  = 0;
    floor_quiet = QUIET_RST;
    floor_jump  = JUMP_RST;
    floor_hard  = HARD_RST;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_floors();
    test_directed_frames();
    test_floor_sweep();
    test_random_scenes();
    test_steady_stream();

    wait_idle();
    if (mismatches == 0) begin
      $display("PASS frame_difference_scene_cut_detector_top");
    end else begin
      $display("FAIL frame_difference_scene_cut_detector_top");
    end
    $finish;
  end

endmodule
